// ===== rtl/dhcp_reply_option_parser_assert.svh =====
// ============================================================================
// DHCP reply option parser assertion macros
// Shared property macros for the concurrent checks of the parser.
// ============================================================================
`ifndef DHCP_REPLY_OPTION_PARSER_ASSERT_SVH
`define DHCP_REPLY_OPTION_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dhcp_rop_pkg.sv =====
// ============================================================================
// DHCP reply option parser package
// Option codes, header layout constants and the result record.
// ============================================================================
package dhcp_rop_pkg;

    localparam logic [7:0] HEADER_BYTES = 8'd240;
    localparam logic [7:0] OFFER_OFFSET = 8'd16;
    localparam logic [7:0] OFFER_END    = 8'd20;

    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_KIND   = 8'd53;
    localparam logic [7:0] OPT_END    = 8'd255;

    localparam logic [7:0] KIND_OFFER = 8'd2;
    localparam logic [7:0] KIND_ACK   = 8'd5;

    localparam logic [7:0] LEN_KIND = 8'd1;
    localparam logic [7:0] LEN_ADDR = 8'd4;

    localparam int RESULT_BITS = 138;
    localparam int TDATA_BITS  = 144;

    typedef enum logic [1:0] {
        ACT_IGNORE,
        ACT_REQUEST,
        ACT_COMMIT,
        ACT_MALFORMED
    } action_t;

    // Declared from the top bit down so that action sits in the lowest bits.
    typedef struct packed {
        logic [7:0]  message_kind;
        logic [31:0] name_server;
        logic [31:0] router_addr;
        logic [31:0] subnet_mask;
        logic [31:0] offered_addr;
        action_t     action;
    } result_t;

endpackage

// ===== rtl/dhcp_rop_parse.sv =====
// ============================================================================
// DHCP reply option parser: byte walker
// Tracks the header and option walk and forms the result on the last byte.
// ============================================================================
module dhcp_rop_parse
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output dhcp_rop_pkg::result_t  result
);
    import dhcp_rop_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_SKIP,
        PH_DONE
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  hcount_reg, hcount_next;
    logic [7:0]  code_reg,   code_next;
    logic [7:0]  left_reg,   left_next;
    logic [31:0] shift_reg,  shift_next;
    logic [31:0] offer_reg,  offer_next;
    logic [7:0]  kind_reg,   kind_next;
    logic [31:0] mask_reg,   mask_next;
    logic [31:0] router_reg, router_next;
    logic [31:0] dns_reg,    dns_next;
    logic        bad_reg,    bad_next;

    logic        known;
    logic        bad_final;

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        code_next   = code_reg;
        left_next   = left_reg;
        shift_next  = shift_reg;
        offer_next  = offer_reg;
        kind_next   = kind_reg;
        mask_next   = mask_reg;
        router_next = router_reg;
        dns_next    = dns_reg;
        bad_next    = bad_reg;
        known = (code_reg == OPT_KIND) || (code_reg == OPT_MASK) ||
                (code_reg == OPT_ROUTER) || (code_reg == OPT_DNS);

        case (phase_reg)
            PH_HEADER:
            begin
                if (hcount_reg >= OFFER_OFFSET && hcount_reg < OFFER_END)
                begin
                    offer_next = {offer_reg[23:0], data_byte};
                end
                hcount_next = hcount_reg + 8'd1;
                if (hcount_next == HEADER_BYTES)
                begin
                    phase_next = PH_CODE;
                end
            end
            PH_CODE:
            begin
                if (data_byte == OPT_END)
                begin
                    phase_next = PH_DONE;
                end
                else if (data_byte != OPT_PAD)
                begin
                    code_next  = data_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                left_next  = data_byte;
                shift_next = '0;
                if (known)
                begin
                    if (data_byte != ((code_reg == OPT_KIND) ? LEN_KIND : LEN_ADDR))
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
                else
                begin
                    phase_next = (data_byte == 8'd0) ? PH_CODE : PH_SKIP;
                end
            end
            PH_VALUE:
            begin
                shift_next = {shift_reg[23:0], data_byte};
                left_next  = left_reg - 8'd1;
                if (left_next == 8'd0)
                begin
                    phase_next = PH_CODE;
                    if (code_reg == OPT_KIND)
                    begin
                        kind_next = shift_next[7:0];
                    end
                    else if (code_reg == OPT_MASK)
                    begin
                        mask_next = shift_next;
                    end
                    else if (code_reg == OPT_ROUTER)
                    begin
                        router_next = shift_next;
                    end
                    else if (code_reg == OPT_DNS)
                    begin
                        dns_next = shift_next;
                    end
                end
            end
            PH_SKIP:
            begin
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0)
                begin
                    phase_next = PH_CODE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The result is formed from the state as it stands after the last byte.
    assign bad_final = bad_next || (hcount_next < HEADER_BYTES);

    always_comb
    begin
        result = '0;
        if (bad_final)
        begin
            result.action = ACT_MALFORMED;
        end
        else
        begin
            if (kind_next == KIND_OFFER)
            begin
                result.action = ACT_REQUEST;
            end
            else if (kind_next == KIND_ACK && mask_next != '0 &&
                     router_next != '0 && dns_next != '0)
            begin
                result.action = ACT_COMMIT;
            end
            else
            begin
                result.action = ACT_IGNORE;
            end
            result.offered_addr = offer_next;
            result.subnet_mask  = mask_next;
            result.router_addr  = router_next;
            result.name_server  = dns_next;
            result.message_kind = kind_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            code_reg   <= '0;
            left_reg   <= '0;
            shift_reg  <= '0;
            offer_reg  <= '0;
            kind_reg   <= '0;
            mask_reg   <= '0;
            router_reg <= '0;
            dns_reg    <= '0;
            bad_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                // The packet is finished: start over for the next one.
                phase_reg  <= PH_HEADER;
                hcount_reg <= '0;
                code_reg   <= '0;
                left_reg   <= '0;
                shift_reg  <= '0;
                offer_reg  <= '0;
                kind_reg   <= '0;
                mask_reg   <= '0;
                router_reg <= '0;
                dns_reg    <= '0;
                bad_reg    <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                hcount_reg <= hcount_next;
                code_reg   <= code_next;
                left_reg   <= left_next;
                shift_reg  <= shift_next;
                offer_reg  <= offer_next;
                kind_reg   <= kind_next;
                mask_reg   <= mask_next;
                router_reg <= router_next;
                dns_reg    <= dns_next;
                bad_reg    <= bad_next;
            end
        end
    end

endmodule

// ===== rtl/dhcp_rop_result.sv =====
// ============================================================================
// DHCP reply option parser: result register
// Holds one result until the downstream side takes the transfer.
// ============================================================================
module dhcp_rop_result
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  dhcp_rop_pkg::result_t  result_in,
    input  logic                   out_ready,
    output logic                   out_valid,
    output dhcp_rop_pkg::result_t  result_out,
    output logic                   slot_free
);
    import dhcp_rop_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

// ===== rtl/dhcp_reply_option_parser.sv =====
// ============================================================================
// DHCP reply option parser
// Walks a received DHCP reply byte by byte and reports the action to take.
// ============================================================================
// Takes one payload byte per cycle with no gaps, but for the stall named below:
// each transfer lands in an input register, the option walker updates its
// state from it as it leaves that register, and on the byte marked last the
// result is loaded into the output register.
// The first 240 bytes are the fixed header, of which only the offered address
// at bytes 16 to 19 is kept. The input side stalls only when a last byte is
// held while an earlier result is still waiting to be taken downstream.

`include "dhcp_reply_option_parser_assert.svh"

module dhcp_reply_option_parser
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // [1:0] action, [33:2] offered_addr,
                                         // [65:34] subnet_mask, [97:66] router_addr,
                                         // [129:98] name_server, [137:130] message_kind
);
    import dhcp_rop_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       slot_free;
    result_t    parsed;
    result_t    held;

    // A byte leaves the input register unless it is a last byte facing a full
    // result register.
    assign advance       = in_valid_reg && (!in_last_reg || slot_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    dhcp_rop_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (parsed)
    );

    dhcp_rop_result u_result
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && in_last_reg),
        .result_in  (parsed),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .result_out (held),
        .slot_free  (slot_free)
    );

    assign m_axis_tdata = {(TDATA_BITS - RESULT_BITS)'(0), held};

    `DRP_ASSERT_SAME(a_malformed_zero, clk, rst_n,
        m_axis_tvalid && held.action == ACT_MALFORMED,
        held.offered_addr == '0 && held.subnet_mask == '0 && held.router_addr == '0
            && held.name_server == '0 && held.message_kind == '0,
        "malformed result carries non-zero fields")

    `DRP_ASSERT_SAME(a_commit_complete, clk, rst_n,
        m_axis_tvalid && held.action == ACT_COMMIT,
        held.message_kind == KIND_ACK && held.subnet_mask != '0
            && held.router_addr != '0 && held.name_server != '0,
        "lease committed without a complete acknowledgement")

    `DRP_ASSERT_NEXT(a_input_held, clk, rst_n,
        in_valid_reg && !advance,
        in_valid_reg && in_last_reg && $stable(in_byte_reg),
        "stalled input byte was lost or altered")

endmodule
